### sv/bblur_pkg.sv
// bblur_pkg: shared types, constants and the rounding divide of the 3x3 box blur
// used by every module of box_blur_3x3_border_aware_unit
`timescale 1ns / 1ps
`default_nettype none

package bblur_pkg;

    localparam int PIX_W             = 8;
    localparam int SUM_W             = 12;
    localparam int CNT_W             = 4;
    localparam int FRAME_W_W         = 11;
    localparam int FRAME_H_W         = 16;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int PIPE_STAGES       = 3;
    localparam int FIFO_DEPTH        = 8;
    localparam int FIFO_PTR_W        = 3;
    localparam int FIFO_LVL_W        = 4;

    localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RESET = 16'd768;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // floor(y / 3) and floor(y / 9) as (y * mul) >> 16, exact for y below 32768
    localparam int              DIV_SHIFT = 16;
    localparam logic [14:0]     DIV3_MUL  = 15'd21846;
    localparam logic [14:0]     DIV9_MUL  = 15'd7282;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    // index 0 upper row, 1 middle row, 2 lower row
    typedef t_pixel [2:0] t_column;

    typedef struct packed {
        t_pixel upper;
        t_pixel middle;
    } t_line_pair;

    typedef struct packed {
        logic emit;
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bot_ok;
        logic row_end;
        logic frame_end;
    } t_ctl;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [CNT_W-1:0] count;
        logic             row_end;
        logic             frame_end;
    } t_sums;

    typedef struct packed {
        t_pixel px;
        logic   row_end;
        logic   frame_end;
    } t_result;

    // floor((2*sum + count) / (2*count)) for count in 1, 2, 3, 4, 6, 9
    function automatic logic [PIX_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                    input logic [CNT_W-1:0] count);
        logic [SUM_W:0]    x;
        logic [SUM_W-1:0]  y;
        logic [14:0]       m;
        logic              use_mul;
        logic [SUM_W+14:0] p;
        logic [SUM_W-1:0]  q;
        x       = {sum, 1'b0} + (SUM_W+1)'(count);
        y       = x[SUM_W:1];
        m       = DIV3_MUL;
        use_mul = 1'b0;
        unique case (count)
            4'd1: begin
                y = x[SUM_W:1];
            end
            4'd2: begin
                y = SUM_W'(x[SUM_W:2]);
            end
            4'd4: begin
                y = SUM_W'(x[SUM_W:3]);
            end
            4'd3: begin
                y       = x[SUM_W:1];
                use_mul = 1'b1;
            end
            4'd6: begin
                y       = SUM_W'(x[SUM_W:2]);
                use_mul = 1'b1;
            end
            4'd9: begin
                y       = x[SUM_W:1];
                m       = DIV9_MUL;
                use_mul = 1'b1;
            end
            default: begin
                y = x[SUM_W:1];
            end
        endcase
        p = (SUM_W+15)'(y) * (SUM_W+15)'(m);
        q = use_mul ? SUM_W'(p[SUM_W+14:DIV_SHIFT]) : y;
        return (q > SUM_W'(255)) ? 8'hFF : q[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/bblur_ctrl.sv
// bblur_ctrl: configuration registers, input and output position counters,
// item acceptance and per-item border flags; uses bblur_pkg
`timescale 1ns / 1ps
`default_nettype none

module bblur_ctrl import bblur_pkg::*; #(
    parameter int  MAX_WIDTH = MAX_WIDTH_DEFAULT,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int WW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_action,
    input  t_pixel                 i_pix,
    input  logic [PIPE_STAGES-1:0] i_busy,
    input  logic [FIFO_LVL_W-1:0]  i_fifo_level,
    output logic                   o_issue,
    output logic [AW-1:0]          o_issue_col,
    output t_pixel                 o_issue_pix,
    output t_ctl                   o_issue_ctl,
    output logic                   o_restart
);

    logic [FRAME_W_W-1:0] r_frame_width, n_frame_width;
    logic [FRAME_H_W-1:0] r_frame_height, n_frame_height;
    logic [AW-1:0]        r_in_col, n_in_col;
    logic [FRAME_H_W:0]   r_in_row, n_in_row;
    logic [AW-1:0]        r_out_col, n_out_col;
    logic [FRAME_H_W-1:0] r_out_row, n_out_row;

    logic [WW-1:0]        w_eff;
    logic [FRAME_H_W-1:0] h_eff;
    logic                 draining;
    logic                 emit;
    logic                 col_last;
    logic                 rend;
    logic                 out_row_last;
    logic                 fend;
    logic                 take;
    logic                 restart;
    logic [FIFO_LVL_W:0]  occupied;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_in_col       <= n_in_col;
            r_in_row       <= n_in_row;
            r_out_col      <= n_out_col;
            r_out_row      <= n_out_row;
        end
    end

    always_comb begin
        occupied = {1'b0, i_fifo_level};
        for (int i = 0; i < PIPE_STAGES; i++) begin
            occupied = occupied + (FIFO_LVL_W+1)'(i_busy[i]);
        end
        o_in_ready  = occupied < (FIFO_LVL_W+1)'(FIFO_DEPTH);
        o_cfg_ready = 1'b1;

        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? FRAME_H_W'(1) : r_frame_height;

        draining     = r_in_row >= {1'b0, h_eff};
        emit         = (r_in_row > (FRAME_H_W+1)'(1))
                    || ((r_in_row == (FRAME_H_W+1)'(1)) && (r_in_col != '0));
        col_last     = (32'(r_in_col) + 32'd1) >= 32'(w_eff);
        rend         = (32'(r_out_col) + 32'd1) >= 32'(w_eff);
        out_row_last = ({1'b0, r_out_row} + (FRAME_H_W+1)'(1)) >= {1'b0, h_eff};
        fend         = rend && out_row_last;
        take         = i_in_valid && o_in_ready && (draining || !i_action);

        o_issue               = take;
        o_issue_col           = r_in_col;
        o_issue_pix           = draining ? '0 : i_pix;
        o_issue_ctl.emit      = emit;
        o_issue_ctl.left_ok   = r_out_col != '0;
        o_issue_ctl.right_ok  = !rend && (r_in_col != '0);
        o_issue_ctl.top_ok    = r_out_row != '0;
        o_issue_ctl.bot_ok    = !out_row_last;
        o_issue_ctl.row_end   = rend;
        o_issue_ctl.frame_end = fend;

        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_in_col       = r_in_col;
        n_in_row       = r_in_row;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        restart        = 1'b0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    n_frame_width = i_cfg_data[FRAME_W_W-1:0];
                    restart       = 1'b1;
                end
                CFG_FRAME_HEIGHT: begin
                    n_frame_height = i_cfg_data[FRAME_H_W-1:0];
                    restart        = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (take) begin
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + (FRAME_H_W+1)'(1);
            end else begin
                n_in_col = r_in_col + AW'(1);
            end
            if (emit) begin
                priority if (fend) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (rend) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + FRAME_H_W'(1);
                end else begin
                    n_out_col = r_out_col + AW'(1);
                end
            end
        end
        o_restart = restart;
    end

endmodule

`default_nettype wire

### sv/bblur_line_buf.sv
// bblur_line_buf: the two line buffers as one memory of row pairs, with
// read-modify-write and forwarding for back-to-back items at the same column; uses bblur_pkg
`timescale 1ns / 1ps
`default_nettype none

module bblur_line_buf import bblur_pkg::*; #(
    parameter int  MAX_WIDTH = MAX_WIDTH_DEFAULT,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_issue,
    input  logic [AW-1:0] i_issue_col,
    input  t_pixel        i_issue_pix,
    input  t_ctl          i_issue_ctl,
    output logic          o_col_valid,
    output t_column       o_col,
    output t_ctl          o_col_ctl
);

    t_line_pair    mem [MAX_WIDTH];
    t_line_pair    r_rd_data;
    t_line_pair    r_fwd_data;
    logic          r_fwd;
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_col;
    t_pixel        r_s1_pix;
    t_ctl          r_s1_ctl;

    t_line_pair    cur;
    t_line_pair    wr_data;

    always_comb begin
        cur            = r_fwd ? r_fwd_data : r_rd_data;
        wr_data.upper  = cur.middle;
        wr_data.middle = r_s1_pix;
        o_col_valid    = r_s1_valid;
        o_col[0]       = cur.upper;
        o_col[1]       = cur.middle;
        o_col[2]       = r_s1_pix;
        o_col_ctl      = r_s1_ctl;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem[r_s1_col] <= wr_data;
        end
        if (i_issue) begin
            r_rd_data <= mem[i_issue_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s1_col   <= i_issue_col;
            r_s1_pix   <= i_issue_pix;
            r_s1_ctl   <= i_issue_ctl;
            r_fwd      <= r_s1_valid && (r_s1_col == i_issue_col);
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue;
        end
    end

endmodule

`default_nettype wire

### sv/bblur_window.sv
// bblur_window: three-column window and the masked neighbor sums and count
// of each emitting item; uses bblur_pkg
`timescale 1ns / 1ps
`default_nettype none

module bblur_window import bblur_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_restart,
    input  logic    i_col_valid,
    input  t_column i_col,
    input  t_ctl    i_col_ctl,
    output logic    o_sums_valid,
    output t_sums   o_sums,
    output logic    o_s2_busy,
    output logic    o_s3_busy
);

    t_column r_win [3];
    logic    r_s2_valid;
    t_ctl    r_s2_ctl;
    logic    r_s3_valid;
    t_sums   r_s3_sums;

    t_sums      n_sums;
    logic [2:0] col_en;
    logic [2:0] row_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            for (int s = 0; s < 3; s++) begin
                r_win[s] <= '0;
            end
        end else if (i_col_valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= i_col;
        end
    end

    always_comb begin
        col_en = {r_s2_ctl.right_ok, 1'b1, r_s2_ctl.left_ok};
        row_en = {r_s2_ctl.bot_ok, 1'b1, r_s2_ctl.top_ok};
        n_sums = '0;
        for (int s = 0; s < 3; s++) begin
            for (int r = 0; r < 3; r++) begin
                if (col_en[s] && row_en[r]) begin
                    n_sums.red   = n_sums.red + SUM_W'(r_win[s][r].red);
                    n_sums.green = n_sums.green + SUM_W'(r_win[s][r].green);
                    n_sums.blue  = n_sums.blue + SUM_W'(r_win[s][r].blue);
                    n_sums.count = n_sums.count + CNT_W'(1);
                end
            end
        end
        n_sums.row_end   = r_s2_ctl.row_end;
        n_sums.frame_end = r_s2_ctl.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_col_valid) begin
            r_s2_ctl <= i_col_ctl;
        end
        if (r_s2_valid) begin
            r_s3_sums <= n_sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_col_valid;
            r_s3_valid <= r_s2_valid && r_s2_ctl.emit;
        end
    end

    assign o_sums_valid = r_s3_valid;
    assign o_sums       = r_s3_sums;
    assign o_s2_busy    = r_s2_valid;
    assign o_s3_busy    = r_s3_valid;

endmodule

`default_nettype wire

### sv/bblur_out.sv
// bblur_out: rounding divide of the sums and the result queue in front of
// the output channel; uses bblur_pkg
`timescale 1ns / 1ps
`default_nettype none

module bblur_out import bblur_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sums_valid,
    input  t_sums                 i_sums,
    output logic [FIFO_LVL_W-1:0] o_level,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_result
);

    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_LVL_W-1:0] r_level, n_level;

    t_result wr_item;
    logic    pop;

    always_comb begin
        wr_item.px.red    = round_mean(i_sums.red, i_sums.count);
        wr_item.px.green  = round_mean(i_sums.green, i_sums.count);
        wr_item.px.blue   = round_mean(i_sums.blue, i_sums.count);
        wr_item.row_end   = i_sums.row_end;
        wr_item.frame_end = i_sums.frame_end;
        o_valid           = r_level != '0;
        pop               = o_valid && i_ready;
        unique case ({i_sums_valid, pop})
            2'b10:   n_level = r_level + FIFO_LVL_W'(1);
            2'b01:   n_level = r_level - FIFO_LVL_W'(1);
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_sums_valid) begin
            r_fifo[r_wr_ptr] <= wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_sums_valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_level <= n_level;
        end
    end

    assign o_result = r_fifo[r_rd_ptr];
    assign o_level  = r_level;

endmodule

`default_nettype wire

### sv/box_blur_3x3_border_aware_unit.sv
// box_blur_3x3_border_aware_unit: streaming 3x3 border-aware box blur of RGB frames
// top level; uses bblur_pkg, bblur_ctrl, bblur_line_buf, bblur_window, bblur_out
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//   in       | i_in_valid / o_in_ready    | i_action, i_in_red, i_in_green, i_in_blue
//   out      | o_out_valid / i_out_ready  | o_out_red/green/blue, o_row_end, o_frame_end
//
// one item per cycle while o_in_ready is high; a result enters the 8-entry output queue after
// the line buffer read, window shift and sums registers, divided on the way in
// o_in_ready drops while queued results plus items in flight fill the queue
// synchronous reset clears counters, window and queue; registers take 1024 x 768
// line buffers are not cleared, entries are written before they are ever used
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_border_aware_unit import bblur_pkg::*; #(
    parameter int  MAX_WIDTH = MAX_WIDTH_DEFAULT,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [PIX_W-1:0]      i_in_red,
    input  logic [PIX_W-1:0]      i_in_green,
    input  logic [PIX_W-1:0]      i_in_blue,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_out_red,
    output logic [PIX_W-1:0]      o_out_green,
    output logic [PIX_W-1:0]      o_out_blue,
    output logic                  o_row_end,
    output logic                  o_frame_end
);

    t_pixel                 in_pix;
    logic                   issue;
    logic [AW-1:0]          issue_col;
    t_pixel                 issue_pix;
    t_ctl                   issue_ctl;
    logic                   restart;
    logic                   col_valid;
    t_column                col;
    t_ctl                   col_ctl;
    logic                   sums_valid;
    t_sums                  sums;
    logic                   s2_busy;
    logic                   s3_busy;
    logic [PIPE_STAGES-1:0] busy;
    logic [FIFO_LVL_W-1:0]  fifo_level;
    t_result                result;

    assign in_pix.red   = i_in_red;
    assign in_pix.green = i_in_green;
    assign in_pix.blue  = i_in_blue;
    assign busy         = {s3_busy, s2_busy, col_valid};

    bblur_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_pix        (in_pix),
        .i_busy       (busy),
        .i_fifo_level (fifo_level),
        .o_issue      (issue),
        .o_issue_col  (issue_col),
        .o_issue_pix  (issue_pix),
        .o_issue_ctl  (issue_ctl),
        .o_restart    (restart)
    );

    bblur_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_issue_col (issue_col),
        .i_issue_pix (issue_pix),
        .i_issue_ctl (issue_ctl),
        .o_col_valid (col_valid),
        .o_col       (col),
        .o_col_ctl   (col_ctl)
    );

    bblur_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_col_valid  (col_valid),
        .i_col        (col),
        .i_col_ctl    (col_ctl),
        .o_sums_valid (sums_valid),
        .o_sums       (sums),
        .o_s2_busy    (s2_busy),
        .o_s3_busy    (s3_busy)
    );

    bblur_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sums_valid (sums_valid),
        .i_sums       (sums),
        .o_level      (fifo_level),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_result     (result)
    );

    assign o_out_red   = result.px.red;
    assign o_out_green = result.px.green;
    assign o_out_blue  = result.px.blue;
    assign o_row_end   = result.row_end;
    assign o_frame_end = result.frame_end;

endmodule

`default_nettype wire

### tb/box_blur_3x3_border_aware_unit_tb.sv
// box_blur_3x3_border_aware_unit_tb: self-checking bench for the 3x3 border-aware box blur
// predicts every blurred pixel from its own line stores and window, checks each result in order
// depends on bblur_pkg and box_blur_3x3_border_aware_unit
`timescale 1ns / 1ps

module box_blur_3x3_border_aware_unit_tb;
    import bblur_pkg::*;

    localparam int          MAX_COLS      = MAX_WIDTH_DEFAULT;
    localparam int unsigned RANDOM_ITEMS  = 1000;
    localparam int unsigned NO_CUT        = 32'hFFFF_FFFF;
    localparam int unsigned WIDE_CUT      = 100;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          TIMEOUT_NS    = 5_000_000;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic   action;
        t_pixel px;
    } t_feed_item;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_action    = 1'b0;
    logic [PIX_W-1:0]      i_in_red    = '0;
    logic [PIX_W-1:0]      i_in_green  = '0;
    logic [PIX_W-1:0]      i_in_blue   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PIX_W-1:0]      o_out_red;
    logic [PIX_W-1:0]      o_out_green;
    logic [PIX_W-1:0]      o_out_blue;
    logic                  o_row_end;
    logic                  o_frame_end;

    box_blur_3x3_border_aware_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_feed_item  feed_q[$];
    t_result     blurred_q[$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned fed_items    = 0;
    int unsigned holds_asked  = 0;

    // predicted block state
    int unsigned pred_width_reg;
    int unsigned pred_height_reg;
    t_pixel      pred_upper [MAX_COLS];
    t_pixel      pred_middle [MAX_COLS];
    t_pixel      pred_win [3][3];
    int unsigned pred_in_col;
    int unsigned pred_in_row;
    int unsigned pred_out_col;
    int unsigned pred_out_row;

    function automatic int unsigned eff_cols(input int unsigned w_reg);
        if (w_reg == 0) return 1;
        if (w_reg > MAX_COLS) return MAX_COLS;
        return w_reg;
    endfunction

    function automatic int unsigned eff_rows(input int unsigned h_reg);
        return (h_reg == 0) ? 1 : h_reg;
    endfunction

    function automatic logic [PIX_W-1:0] half_up_mean(input int unsigned sum,
                                                      input int unsigned count);
        int unsigned v;
        v = (2 * sum + count) / (2 * count);
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    // mean of in-frame neighbors around window slot center (1 or 2)
    function automatic t_pixel window_mean(input int unsigned center, input int unsigned w,
                                           input int unsigned h);
        logic        col_ok [3];
        logic        row_ok [3];
        int unsigned sum_r, sum_g, sum_b, count, slot;
        t_pixel      px, mean_px;
        col_ok[0] = pred_out_col >= 1;
        col_ok[1] = 1'b1;
        col_ok[2] = (pred_out_col + 1 < w) && (center < 2);
        row_ok[0] = pred_out_row >= 1;
        row_ok[1] = 1'b1;
        row_ok[2] = pred_out_row + 1 < h;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        count = 0;
        for (int dc = 0; dc < 3; dc++) begin
            slot = center + dc - 1;
            if (col_ok[dc] && slot <= 2) begin
                for (int r = 0; r < 3; r++) begin
                    if (row_ok[r]) begin
                        px = pred_win[slot][r];
                        sum_r += px.red;
                        sum_g += px.green;
                        sum_b += px.blue;
                        count++;
                    end
                end
            end
        end
        mean_px.red   = half_up_mean(sum_r, count);
        mean_px.green = half_up_mean(sum_g, count);
        mean_px.blue  = half_up_mean(sum_b, count);
        return mean_px;
    endfunction

    task automatic restart_prediction();
        for (int s = 0; s < 3; s++) begin
            for (int r = 0; r < 3; r++) begin
                pred_win[s][r] = '0;
            end
        end
        pred_in_col  = 0;
        pred_in_row  = 0;
        pred_out_col = 0;
        pred_out_row = 0;
    endtask

    task automatic blur_predict_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_FRAME_WIDTH) begin
            pred_width_reg = data[FRAME_W_W-1:0];
        end else if (idx == CFG_FRAME_HEIGHT) begin
            pred_height_reg = data;
        end else begin
            return;
        end
        restart_prediction();
    endtask

    task automatic blur_predict_item(input logic act, input t_pixel px_in);
        int unsigned w, h, ic;
        logic        emit, rend, fend;
        t_pixel      px, mean_px;
        t_result     exp_res;
        w = eff_cols(pred_width_reg);
        h = eff_rows(pred_height_reg);
        // drain before the last pixel is ignored
        if (pred_in_row < h && act == ACT_DRAIN) return;
        px      = (pred_in_row < h) ? px_in : '0;
        ic      = (pred_in_col >= MAX_COLS) ? 0 : pred_in_col;
        emit    = (pred_in_row > 1) || (pred_in_row == 1 && ic >= 1);
        mean_px = '0;
        if (ic == 0 && emit) mean_px = window_mean(2, w, h);
        for (int r = 0; r < 3; r++) begin
            pred_win[0][r] = pred_win[1][r];
            pred_win[1][r] = pred_win[2][r];
        end
        pred_win[2][0]  = pred_upper[ic];
        pred_win[2][1]  = pred_middle[ic];
        pred_win[2][2]  = px;
        pred_upper[ic]  = pred_middle[ic];
        pred_middle[ic] = px;
        if (ic != 0 && emit) mean_px = window_mean(1, w, h);
        pred_in_col = ic + 1;
        if (pred_in_col >= w) begin
            pred_in_col = 0;
            pred_in_row++;
        end
        if (!emit) return;
        rend              = pred_out_col + 1 >= w;
        fend              = rend && (pred_out_row + 1 >= h);
        exp_res.px        = mean_px;
        exp_res.row_end   = rend;
        exp_res.frame_end = fend;
        blurred_q.push_back(exp_res);
        if (fend) begin
            pred_in_col  = 0;
            pred_in_row  = 0;
            pred_out_col = 0;
            pred_out_row = 0;
        end else if (rend) begin
            pred_out_col = 0;
            pred_out_row++;
        end else begin
            pred_out_col++;
        end
    endtask

    // monitor: check results, then track accepted config and items
    t_result got_res, want_res;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pred_width_reg  = FRAME_WIDTH_RESET;
            pred_height_reg = FRAME_HEIGHT_RESET;
            restart_prediction();
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_res = {o_out_red, o_out_green, o_out_blue, o_row_end, o_frame_end};
                if (blurred_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("result %0d: none expected, got rgb %0d %0d %0d re %0b fe %0b",
                                 results_seen, got_res.px.red, got_res.px.green,
                                 got_res.px.blue, got_res.row_end, got_res.frame_end);
                    mismatches++;
                end else begin
                    want_res = blurred_q.pop_front();
                    if (got_res.px.red !== want_res.px.red ||
                        got_res.px.green !== want_res.px.green ||
                        got_res.px.blue !== want_res.px.blue ||
                        got_res.row_end !== want_res.row_end ||
                        got_res.frame_end !== want_res.frame_end) begin
                        if (mismatches < 10) begin
                            $write("result %0d: expected rgb %0d %0d %0d re %0b fe %0b,",
                                   results_seen, want_res.px.red, want_res.px.green,
                                   want_res.px.blue, want_res.row_end, want_res.frame_end);
                            $display(" got rgb %0d %0d %0d re %0b fe %0b",
                                     got_res.px.red, got_res.px.green, got_res.px.blue,
                                     got_res.row_end, got_res.frame_end);
                        end
                        mismatches++;
                    end
                end
                results_seen++;
            end
            if (i_cfg_valid && o_cfg_ready) blur_predict_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                blur_predict_item(i_action, {i_in_red, i_in_green, i_in_blue});
        end
    end

    // item driver: bursts of random length with random gaps
    t_feed_item  next_item;
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0 || feed_q.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_in_valid <= 1'b0;
            end else begin
                next_item = feed_q.pop_front();
                i_in_valid <= 1'b1;
                i_action   <= next_item.action;
                i_in_red   <= next_item.px.red;
                i_in_green <= next_item.px.green;
                i_in_blue  <= next_item.px.blue;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // result receiver: rotating stall mask, plus long hold-offs on request
    logic [15:0] stall_mask;
    int unsigned pattern_left;
    int unsigned hold_left;
    int unsigned holds_served;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_mask   = 16'hFFFF;
            pattern_left = 0;
            hold_left    = 0;
            holds_served = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(32, 400);
                case ($urandom_range(0, 3))
                    0:       stall_mask = 16'hFFFF;
                    1:       stall_mask = 16'($urandom) | 16'h0101;
                    2:       stall_mask = 16'hF0F7;
                    default: stall_mask = 16'($urandom);
                endcase
                if (stall_mask == '0) stall_mask = 16'h8000;
            end else begin
                pattern_left--;
            end
            stall_mask = {stall_mask[14:0], stall_mask[15]};
            i_out_ready <= stall_mask[0];
        end
    end

    function automatic t_pixel random_pixel();
        t_pixel px;
        px = 24'($urandom);
        case ($urandom_range(0, 7))
            0:       px = '0;
            1:       px = '1;
            2:       px.green = 8'hFF;
            3:       px.blue = 8'h00;
            default: ;
        endcase
        return px;
    endfunction

    task automatic push_item(input logic act, input t_pixel px);
        t_feed_item it;
        it.action = act;
        it.px     = px;
        feed_q.push_back(it);
    endtask

    // everything sent and every result back, then let the pipeline settle
    task automatic wait_idle();
        while (feed_q.size() != 0 || i_in_valid || blurred_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data, input logic spare_writes);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_FRAME_WIDTH, w_data);
            write_reg(CFG_FRAME_HEIGHT, h_data);
        end else begin
            write_reg(CFG_FRAME_HEIGHT, h_data);
            write_reg(CFG_FRAME_WIDTH, w_data);
        end
        if (spare_writes) begin
            write_reg(CFG_SPARE_A, 16'($urandom));
            write_reg(CFG_SPARE_B, 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // one frame: pixels with stray early drains, then W+1 drain ticks
    task automatic queue_frame(input int unsigned w, input int unsigned h,
                               input int unsigned cut_at, input int unsigned pause_at);
        int unsigned total;
        total = w * h + w + 1;
        for (int unsigned k = 0; k < total && k < cut_at; k++) begin
            if (k == pause_at) wait_idle();
            if (k < w * h) begin
                if ($urandom_range(0, 19) == 0) push_item(ACT_DRAIN, random_pixel());
                push_item(ACT_PIXEL, random_pixel());
            end else begin
                push_item($urandom_range(0, 1) ? ACT_DRAIN : ACT_PIXEL, random_pixel());
            end
            fed_items++;
        end
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned      w, h, total, cut, pause, phase, sel, w_raw, h_raw;
        logic [15:0]      w_data, h_data;
        logic             chain_ok, hold_phase;
        t_pixel           px;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size: early drain ignored, one pixel still in warm-up
        push_item(ACT_DRAIN, '1);
        push_item(ACT_PIXEL, {8'hFF, 8'h00, 8'h80});
        wait_idle();

        // 3x3: corners, edges and the full interior
        set_frame(16'd3, 16'd3, 1'b0);
        for (int k = 0; k < 9; k++) begin
            px = ((k + k / 3) % 2) ? '0 : '1;
            if (k == 4) px = {8'd128, 8'd127, 8'd1};
            if (k == 2) push_item(ACT_DRAIN, '1);
            push_item(ACT_PIXEL, px);
        end
        for (int k = 0; k < 4; k++) push_item((k == 1) ? ACT_PIXEL : ACT_DRAIN, '1);
        wait_idle();

        // zero sizes act as one
        set_frame(16'd0, 16'd0, 1'b0);
        push_item(ACT_PIXEL, {8'hFF, 8'h00, 8'h81});
        push_item(ACT_DRAIN, '0);
        push_item(ACT_PIXEL, '1);
        wait_idle();

        // single row, spare register indexes written too
        set_frame(16'd3, 16'd1, 1'b1);
        push_item(ACT_PIXEL, '1);
        push_item(ACT_PIXEL, {8'h00, 8'h00, 8'h01});
        push_item(ACT_PIXEL, '0);
        for (int k = 0; k < 4; k++) push_item(ACT_DRAIN, '0);
        wait_idle();

        // oversized width clamps to the full line, still in warm-up when cut
        set_frame(16'hFFFF, 16'd1, 1'b0);
        queue_frame(MAX_COLS, 1, WIDE_CUT, NO_CUT);

        fed_items = 0;
        phase     = 0;
        chain_ok  = 1'b0;
        w_data    = '0;
        h_data    = '0;
        while (fed_items < RANDOM_ITEMS) begin
            hold_phase = (phase == 2) || (phase == 11);
            if (!chain_ok || hold_phase || $urandom_range(0, 9) < 6) begin
                if (hold_phase) begin
                    w_data = 16'd12;
                    h_data = 16'd6;
                end else if (phase == 0) begin
                    w_data = 16'd4;
                    h_data = 16'hFFFF;
                end else begin
                    sel   = $urandom_range(0, 99);
                    w_raw = (sel < 4)  ? 0 :
                            (sel < 55) ? $urandom_range(1, 6) :
                            (sel < 88) ? $urandom_range(7, 20) : $urandom_range(21, 64);
                    sel   = $urandom_range(0, 99);
                    h_raw = (sel < 4)  ? 0 :
                            (sel < 60) ? $urandom_range(1, 4) :
                            (sel < 95) ? $urandom_range(5, 10) : $urandom_range(11, 65535);
                    if (w_raw > 20 && h_raw > 3 && h_raw <= 10) h_raw = $urandom_range(1, 3);
                    w_data = {5'($urandom), 11'(w_raw)};
                    h_data = 16'(h_raw);
                end
                wait_idle();
                set_frame(w_data, h_data, $urandom_range(0, 7) == 0);
            end
            w     = eff_cols(w_data[FRAME_W_W-1:0]);
            h     = eff_rows(h_data);
            total = w * h + w + 1;
            cut   = NO_CUT;
            pause = NO_CUT;
            if (!hold_phase) begin
                if (h > 10 || $urandom_range(0, 6) == 0)
                    cut = $urandom_range(1, (total > 150) ? 150 : total - 1);
                if ($urandom_range(0, 5) == 0) pause = $urandom_range(1, total - 1);
            end
            queue_frame(w, h, cut, pause);
            chain_ok = (cut == NO_CUT);
            if (hold_phase) holds_asked <= holds_asked + 1;
            phase++;
        end

        wait_idle();
        if (mismatches == 0 && blurred_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
